// ===== design/bms_pkg.sv =====
package bms_pkg;

  // Scan modes as written to the scan_mode register
  typedef enum logic [1:0] {
    MODE_FWD_CLOSE  = 2'd0,
    MODE_BWD_OPEN   = 2'd1,
    MODE_BWD_ENCL   = 2'd2,
    MODE_FWD_PREFIX = 2'd3
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_NONE     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Character classes
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_CLOSE = 2'd2
  } class_e;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CHAR_W   = 8;

  // Bracket kinds
  localparam logic [KIND_W-1:0] KIND_ROUND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

  // Bracket characters
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_KIND = 2'd1;

  typedef struct packed {
    class_e              cls;
    logic [KIND_W-1:0]   kind;
  } bracket_t;

  // Stack command from the decision logic to the stack
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic set_done;
  } stack_op_t;

  function automatic bracket_t classify(logic [CHAR_W-1:0] ch);
    bracket_t b;
    b.cls  = CLS_NONE;
    b.kind = KIND_ROUND;
    case (ch)
      CH_LPAREN: begin b.cls = CLS_OPEN;  b.kind = KIND_ROUND;  end
      CH_RPAREN: begin b.cls = CLS_CLOSE; b.kind = KIND_ROUND;  end
      CH_LBRACK: begin b.cls = CLS_OPEN;  b.kind = KIND_SQUARE; end
      CH_RBRACK: begin b.cls = CLS_CLOSE; b.kind = KIND_SQUARE; end
      CH_LBRACE: begin b.cls = CLS_OPEN;  b.kind = KIND_CURLY;  end
      CH_RBRACE: begin b.cls = CLS_CLOSE; b.kind = KIND_CURLY;  end
      default:   begin b.cls = CLS_NONE;  b.kind = KIND_ROUND;  end
    endcase
    return b;
  endfunction

endpackage

// ===== design/bms_stack.sv =====
module bms_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             fire_i,
  input  bms_pkg::stack_op_t                               op_i,
  input  logic [bms_pkg::KIND_W+LINE_BITS+COLUMN_BITS-1:0] new_ent_i,
  output logic [$clog2(STACK_DEPTH+1)-1:0]                 count_o,
  output logic [bms_pkg::KIND_W+LINE_BITS+COLUMN_BITS-1:0] top_o,
  output logic [bms_pkg::KIND_W+LINE_BITS+COLUMN_BITS-1:0] under_o,
  output logic                                             done_o
);
  import bms_pkg::*;

  localparam int EntW  = KIND_W + LINE_BITS + COLUMN_BITS;
  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);

  // Entries below the top; the top lives in top_q, the next one down in under_q
  logic [EntW-1:0]  mem [STACK_DEPTH];
  logic [EntW-1:0]  top_q, under_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  eff_count;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;

  // Work out the count after this word and the memory addresses
  always_comb begin
    eff_count = op_i.clear ? '0 : count_q;
    count_d   = eff_count + CntW'(op_i.push) - CntW'(op_i.pop);
    done_d    = op_i.set_done ? 1'b1 : (op_i.clear ? 1'b0 : done_q);
    wr_en     = fire_i && op_i.push && (eff_count != '0);
    wr_addr   = AddrW'(eff_count - CntW'(1));
    rd_addr   = (count_d >= CntW'(2)) ? AddrW'(count_d - CntW'(2)) : '0;
  end

  // Spill the old top on a push, prefetch the entry under the new top
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= top_q;
    end
    if (fire_i) begin
      under_q <= op_i.push ? top_q : mem[rd_addr];
      if (op_i.push) begin
        top_q <= new_ent_i;
      end else if (op_i.pop) begin
        top_q <= under_q;
      end
    end
  end

  // Hold count and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else if (fire_i) begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  assign count_o = count_q;
  assign top_o   = top_q;
  assign under_o = under_q;
  assign done_o  = done_q;

endmodule

// ===== design/bms_step.sv =====
module bms_step #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic [bms_pkg::CHAR_W-1:0]                       char_i,
  input  logic [LINE_BITS-1:0]                             line_i,
  input  logic [COLUMN_BITS-1:0]                           column_i,
  input  logic                                             skip_i,
  input  logic                                             first_i,
  input  logic                                             last_i,
  input  bms_pkg::mode_e                                   mode_i,
  input  logic [bms_pkg::KIND_W-1:0]                       target_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]                 count_i,
  input  logic [bms_pkg::KIND_W+LINE_BITS+COLUMN_BITS-1:0] top_i,
  input  logic [bms_pkg::KIND_W+LINE_BITS+COLUMN_BITS-1:0] under_i,
  input  logic                                             done_i,
  output bms_pkg::stack_op_t                               op_o,
  output logic [bms_pkg::KIND_W+LINE_BITS+COLUMN_BITS-1:0] new_ent_o,
  output logic                                             emit_o,
  output bms_pkg::status_e                                 status_o,
  output logic [bms_pkg::KIND_W-1:0]                       kind_o,
  output logic [LINE_BITS-1:0]                             line_o,
  output logic [COLUMN_BITS-1:0]                           column_o
);
  import bms_pkg::*;

  localparam int EntW = KIND_W + LINE_BITS + COLUMN_BITS;
  localparam int CntW = $clog2(STACK_DEPTH + 1);

  bracket_t        br;
  logic [CntW-1:0] eff_count;
  logic            eff_done, empty, full, is_push, pushes_closer, nonempty_after;
  logic [EntW-1:0] next_top;
  logic [KIND_W-1:0] top_kind;

  // Classify the character and take the search state as this word sees it
  always_comb begin
    br = classify(char_i);
    if (skip_i) begin
      br.cls = CLS_NONE;
    end
    eff_count     = first_i ? '0 : count_i;
    eff_done      = first_i ? 1'b0 : done_i;
    empty         = (eff_count == '0);
    full          = (eff_count == CntW'(STACK_DEPTH));
    pushes_closer = (mode_i == MODE_BWD_OPEN) || (mode_i == MODE_BWD_ENCL);
    is_push       = (br.cls != CLS_NONE) && ((br.cls == CLS_CLOSE) == pushes_closer);
    top_kind      = top_i[EntW-1 -: KIND_W];
  end

  assign new_ent_o = {br.kind, line_i, column_i};

  // Decide push, pop or result
  always_comb begin
    op_o           = '0;
    op_o.clear     = first_i;
    emit_o         = 1'b0;
    status_o       = ST_NONE;
    kind_o         = '0;
    line_o         = '0;
    column_o       = '0;
    nonempty_after = 1'b0;
    next_top       = top_i;
    if (!eff_done) begin
      if (is_push) begin
        if (full) begin
          emit_o   = 1'b1;
          status_o = ST_OVERFLOW;
        end else begin
          op_o.push = 1'b1;
        end
      end else if (br.cls != CLS_NONE) begin
        if (empty) begin
          case (mode_i)
            MODE_BWD_ENCL: begin
              emit_o   = 1'b1;
              status_o = ST_FOUND;
              kind_o   = br.kind;
              line_o   = line_i;
              column_o = column_i;
            end
            MODE_FWD_CLOSE, MODE_BWD_OPEN: begin
              emit_o = 1'b1;
              if (br.kind == target_i) begin
                status_o = ST_FOUND;
                kind_o   = br.kind;
                line_o   = line_i;
                column_o = column_i;
              end else begin
                status_o = ST_MISMATCH;
              end
            end
            default: ; // stray closer in the prefix scan: drop it
          endcase
        end else if (top_kind == br.kind) begin
          op_o.pop = 1'b1;
        end else begin
          emit_o   = 1'b1;
          status_o = ST_MISMATCH;
        end
      end

      // End of range: report the open top in prefix mode, otherwise nothing found
      nonempty_after = op_o.push || (op_o.pop ? (eff_count > CntW'(1)) : !empty);
      if (op_o.push) begin
        next_top = new_ent_o;
      end else if (op_o.pop) begin
        next_top = under_i;
      end
      if (!emit_o && last_i) begin
        emit_o = 1'b1;
        if ((mode_i == MODE_FWD_PREFIX) && nonempty_after) begin
          status_o = ST_FOUND;
          kind_o   = next_top[EntW-1 -: KIND_W];
          line_o   = next_top[COLUMN_BITS +: LINE_BITS];
          column_o = next_top[COLUMN_BITS-1:0];
        end else begin
          status_o = ST_NONE;
        end
      end
    end
    op_o.set_done = emit_o;
  end

endmodule

// ===== design/bracket_match_scanner.sv =====
// An accepted word is held in the input register and its result registered onto m_axis
// when the result slot is free or draining; a waiting result delays it until taken.
// Throughput: one character per cycle; the stack top and the entry beneath it sit in
// registers and the stack memory is prefetched one entry ahead, so a push or pop never waits.
// While a result waits, one more word is taken into the input register and the input
// then stalls until the result is taken.
// Reset (rst_ni low, asynchronous) clears valids, stack count, done flag and configuration;
// the stack memory is not cleared and needs no clearing pass.
module bracket_match_scanner #(
  parameter int STACK_DEPTH = 64,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  // character[7:0], line_number, column_number
  input  logic [((8+LINE_BITS+COLUMN_BITS+7)/8)*8-1:0]         s_axis_tdata,
  // skip[0], first_item[1]
  input  logic [1:0]                                           s_axis_tuser,
  input  logic                                                 s_axis_tlast,
  input  logic                                                 s_axis_tvalid,
  output logic                                                 s_axis_tready,
  // status[1:0], found_kind[3:2], found_line, found_column
  output logic [((4+LINE_BITS+COLUMN_BITS+7)/8)*8-1:0]         m_axis_tdata,
  output logic                                                 m_axis_tvalid,
  input  logic                                                 m_axis_tready,
  input  logic                                                 cfg_valid_i,
  output logic                                                 cfg_ready_o,
  input  logic [bms_pkg::CFG_IDX_W-1:0]                        cfg_index_i,
  input  logic [bms_pkg::CFG_DATA_W-1:0]                       cfg_data_i
);
  import bms_pkg::*;

  localparam int EntW = KIND_W + LINE_BITS + COLUMN_BITS;
  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int OutW = ((4 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8;

  mode_e              mode_q;
  logic [KIND_W-1:0]  target_q;

  logic                   in_vld_q;
  logic [CHAR_W-1:0]      in_char_q;
  logic [LINE_BITS-1:0]   in_line_q;
  logic [COLUMN_BITS-1:0] in_col_q;
  logic                   in_skip_q, in_first_q, in_last_q;

  logic                   out_vld_q;
  status_e                out_status_q;
  logic [KIND_W-1:0]      out_kind_q;
  logic [LINE_BITS-1:0]   out_line_q;
  logic [COLUMN_BITS-1:0] out_col_q;

  logic                   proc_fire;
  stack_op_t              op;
  logic [EntW-1:0]        new_ent, top, under;
  logic [CntW-1:0]        count;
  logic                   done;
  logic                   emit;
  status_e                res_status;
  logic [KIND_W-1:0]      res_kind;
  logic [LINE_BITS-1:0]   res_line;
  logic [COLUMN_BITS-1:0] res_col;

  // Process the held word when the result slot is free or draining
  assign proc_fire     = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc_fire;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_FWD_CLOSE;
      target_q <= KIND_ROUND;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCAN_MODE:   mode_q   <= mode_e'(cfg_data_i);
        CFG_TARGET_KIND: target_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q  <= s_axis_tdata[CHAR_W-1:0];
      in_line_q  <= s_axis_tdata[CHAR_W +: LINE_BITS];
      in_col_q   <= s_axis_tdata[CHAR_W+LINE_BITS +: COLUMN_BITS];
      in_skip_q  <= s_axis_tuser[0];
      in_first_q <= s_axis_tuser[1];
      in_last_q  <= s_axis_tlast;
    end
  end

  bms_step #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_step (
    .char_i    (in_char_q),
    .line_i    (in_line_q),
    .column_i  (in_col_q),
    .skip_i    (in_skip_q),
    .first_i   (in_first_q),
    .last_i    (in_last_q),
    .mode_i    (mode_q),
    .target_i  (target_q),
    .count_i   (count),
    .top_i     (top),
    .under_i   (under),
    .done_i    (done),
    .op_o      (op),
    .new_ent_o (new_ent),
    .emit_o    (emit),
    .status_o  (res_status),
    .kind_o    (res_kind),
    .line_o    (res_line),
    .column_o  (res_col)
  );

  bms_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (proc_fire),
    .op_i      (op),
    .new_ent_i (new_ent),
    .count_o   (count),
    .top_o     (top),
    .under_o   (under),
    .done_o    (done)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_fire) begin
      out_vld_q <= emit;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && emit) begin
      out_status_q <= res_status;
      out_kind_q   <= res_kind;
      out_line_q   <= res_line;
      out_col_q    <= res_col;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'({out_col_q, out_line_q, out_kind_q, out_status_q});

endmodule

// ===== design/bms_checker.sv =====
module bms_checker #(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input logic                                         clk_i,
  input logic                                         rst_ni,
  input logic                                         s_axis_tready,
  input logic [((4+LINE_BITS+COLUMN_BITS+7)/8)*8-1:0] m_axis_tdata,
  input logic                                         m_axis_tvalid,
  input logic                                         m_axis_tready
);
  import bms_pkg::*;

  localparam int FieldW = KIND_W + LINE_BITS + COLUMN_BITS;

  logic [STATUS_W-1:0] res_status;
  logic [KIND_W-1:0]   res_kind;
  logic [FieldW-1:0]   res_fields;

  assign res_status = m_axis_tdata[STATUS_W-1:0];
  assign res_kind   = m_axis_tdata[STATUS_W +: KIND_W];
  assign res_fields = m_axis_tdata[STATUS_W +: FieldW];

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // An empty result slot never blocks the input side
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no result pending");

  // Only a found result carries kind and position
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_status != ST_FOUND) |-> (res_fields == '0))
    else $error("non-found result carries position data");

  // A found bracket is always one of the three real kinds
  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res_status == ST_FOUND) |-> (res_kind != KIND_INVALID))
    else $error("found result with invalid kind");

endmodule

bind bracket_match_scanner bms_checker #(
  .LINE_BITS   (LINE_BITS),
  .COLUMN_BITS (COLUMN_BITS)
) u_bms_checker (.*);
